@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame energy unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/frms_pkg.sv @@
// ----------------------------------------------------------------------------
// frms_pkg
// Shared constants for the framed RMS energy and onset unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frms_pkg;

    localparam int HOP_LENGTH_DEF     = 512;
    localparam int HOPS_PER_FRAME_DEF = 4;

    // frame jobs buffered between front and back end
    localparam int QUEUE_DEPTH = 4;

    localparam int SAMPLE_W = 16;
    // square of a sample magnitude is at most 2^30
    localparam int SQ_W     = 31;
    // radicand (mean square) is padded to an even bit count
    localparam int RAD_W    = 32;
    localparam int ROOT_W   = 16;

endpackage

@@ design/frms_queue.sv @@
// ----------------------------------------------------------------------------
// frms_queue
// Small FIFO of frame jobs between the accumulation front end and the
// divide and root back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frms_queue
    import frms_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // front end must hold off while the queue is full
    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full)

endmodule

@@ design/frms_front.sv @@
// ----------------------------------------------------------------------------
// frms_front
// Sample intake: squares each sample, keeps per-hop block sums and the
// running sum of the pending frame, and posts one job per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frms_front
    import frms_pkg::*;
#(
    parameter int HOP_LENGTH     = HOP_LENGTH_DEF,
    parameter int HOPS_PER_FRAME = HOPS_PER_FRAME_DEF,
    parameter int SUM_W          = SQ_W + $clog2(HOP_LENGTH * HOPS_PER_FRAME),
    parameter int AV_W           = $clog2(HOP_LENGTH * HOPS_PER_FRAME + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [SAMPLE_W-1:0]       s_axis_tdata,
    input  logic                      s_axis_tlast,
    output logic                      job_valid,
    output logic [SUM_W+AV_W:0]       job_data,   // sum, available, last
    input  logic                      job_ready
);

    localparam int POS_W  = $clog2(HOP_LENGTH);
    localparam int CNT_W  = (HOPS_PER_FRAME > 1) ? $clog2(HOPS_PER_FRAME) : 1;
    localparam int HELD_N = (HOPS_PER_FRAME > 1) ? HOPS_PER_FRAME - 1 : 1;
    localparam int BLK_W  = SQ_W + $clog2(HOP_LENGTH);

    logic [SAMPLE_W-1:0] mag;
    logic [31:0]         prod;
    logic                s_accept;
    logic                advance;

    logic                s1_valid_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic                eos_reg;

    logic [BLK_W-1:0]    cur_reg;
    logic [BLK_W-1:0]    cur_next;
    logic [SUM_W-1:0]    frame_acc_reg;
    logic [SUM_W-1:0]    frame_acc_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [BLK_W-1:0]    held_reg  [HELD_N];
    logic [BLK_W-1:0]    held_next [HELD_N];

    logic [BLK_W-1:0]    cur_plus;
    logic [SUM_W-1:0]    job_sum;
    logic [SUM_W-1:0]    oldest;
    logic [AV_W-1:0]     job_avail;
    logic                block_done;
    logic                frame_done;
    logic                do_shift;
    logic                do_push;

    // stage 1: magnitude and square
    assign mag  = s_axis_tdata[SAMPLE_W-1] ? (~s_axis_tdata + 1'b1) : s_axis_tdata;
    assign prod = 32'(mag) * 32'(mag);

    assign advance       = s1_valid_reg && job_ready;
    assign s_axis_tready = !s1_valid_reg || job_ready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            sq_reg  <= prod[SQ_W-1:0];
            eos_reg <= s_axis_tlast;
        end
    end

    // stage 2: block and frame bookkeeping
    assign cur_plus   = cur_reg + BLK_W'(sq_reg);
    assign job_sum    = frame_acc_reg + SUM_W'(sq_reg);
    assign block_done = (pos_reg == POS_W'(HOP_LENGTH - 1));
    assign frame_done = block_done && (cnt_reg == CNT_W'(HOPS_PER_FRAME - 1));
    assign job_avail  = AV_W'(cnt_reg) * AV_W'(HOP_LENGTH) + AV_W'(pos_reg) + 1'b1;
    assign oldest     = (HOPS_PER_FRAME > 1) ? SUM_W'(held_reg[0]) : job_sum;

    assign job_valid = advance && (frame_done || eos_reg);
    assign job_data  = {eos_reg, job_avail, job_sum};

    assign do_shift = advance && !eos_reg && frame_done && (HOPS_PER_FRAME > 1);
    assign do_push  = advance && !eos_reg && block_done && !frame_done;

    always_comb
    begin
        cur_next       = cur_reg;
        frame_acc_next = frame_acc_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        if (advance)
        begin
            if (eos_reg)
            begin
                cur_next       = '0;
                frame_acc_next = '0;
                pos_next       = '0;
                cnt_next       = '0;
            end
            else if (frame_done)
            begin
                // drop the oldest block from the running sum
                cur_next       = '0;
                pos_next       = '0;
                frame_acc_next = job_sum - oldest;
            end
            else if (block_done)
            begin
                cur_next       = '0;
                pos_next       = '0;
                cnt_next       = cnt_reg + 1'b1;
                frame_acc_next = job_sum;
            end
            else
            begin
                cur_next       = cur_plus;
                pos_next       = pos_reg + 1'b1;
                frame_acc_next = job_sum;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < HELD_N; i++)
        begin
            held_next[i] = held_reg[i];
            if (do_shift)
            begin
                held_next[i] = (i == HELD_N - 1) ? cur_plus : held_reg[(i + 1) % HELD_N];
            end
            else if (do_push && (cnt_reg == CNT_W'(i)))
            begin
                held_next[i] = cur_plus;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            frame_acc_reg <= '0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            cur_reg       <= cur_next;
            frame_acc_reg <= frame_acc_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HELD_N; i++)
        begin
            held_reg[i] <= held_next[i];
        end
    end

    `ASSERT_IMPLIES(a_pos_range, clk, rst_n, 1'b1, pos_reg <= POS_W'(HOP_LENGTH - 1))
    `ASSERT_NEXT(a_eos_clears, clk, rst_n, advance && eos_reg, (pos_reg == '0) && (cnt_reg == '0) && (frame_acc_reg == '0))

endmodule

@@ design/frms_back.sv @@
// ----------------------------------------------------------------------------
// frms_back
// Frame job execution: mean square by restoring division, integer root
// two bits a step, onset against the previous frame, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frms_back
    import frms_pkg::*;
#(
    parameter int SUM_W = 42,
    parameter int AV_W  = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    input  logic [SUM_W+AV_W:0]   job_data,   // sum, available, last
    output logic                  job_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [2*ROOT_W-1:0]   m_axis_tdata,   // energy, onset
    output logic                  m_axis_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SQRT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam int STEP_W = $clog2(SUM_W + 1);
    localparam int SREM_W = ROOT_W + 2;
    localparam int SSH_W  = ROOT_W + 4;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    logic [SUM_W-1:0]  dvd_reg;
    logic [SUM_W-1:0]  dvd_next;
    logic [AV_W-1:0]   dvs_reg;
    logic [AV_W-1:0]   dvs_next;
    logic [AV_W-1:0]   rem_reg;
    logic [AV_W-1:0]   rem_next;
    logic              last_reg;
    logic              last_next;

    logic [RAD_W-1:0]  rad_reg;
    logic [RAD_W-1:0]  rad_next;
    logic [SREM_W-1:0] srem_reg;
    logic [SREM_W-1:0] srem_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic [ROOT_W-1:0] prev_reg;

    logic              out_valid_reg;
    logic [ROOT_W-1:0] energy_out_reg;
    logic [ROOT_W-1:0] onset_out_reg;
    logic              last_out_reg;

    logic [AV_W:0]     rem_sh;
    logic              div_ge;
    logic [SSH_W-1:0]  srem_sh;
    logic [SSH_W-1:0]  trial;
    logic              sqrt_ge;
    logic              out_load;
    logic [ROOT_W-1:0] onset_val;

    assign job_pop  = (state_reg == ST_IDLE) && job_valid;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    assign rem_sh  = {rem_reg, dvd_reg[SUM_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, dvs_reg});
    assign srem_sh = {srem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign sqrt_ge = (srem_sh >= trial);

    assign onset_val = (root_reg > prev_reg) ? (root_reg - prev_reg) : '0;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        last_next  = last_reg;
        rad_next   = rad_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    dvd_next   = job_data[SUM_W-1:0];
                    dvs_next   = job_data[SUM_W +: AV_W];
                    last_next  = job_data[SUM_W+AV_W];
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle, quotient shifts in from the bottom
                rem_next  = div_ge ? AV_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[AV_W-1:0];
                dvd_next  = {dvd_reg[SUM_W-2:0], div_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    rad_next   = dvd_next[RAD_W-1:0];
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                // one root bit per cycle from two radicand bits
                srem_next = sqrt_ge ? SREM_W'(srem_sh - trial) : srem_sh[SREM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], sqrt_ge};
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (out_load)
            begin
                // the last frame of a stream restarts the onset reference
                prev_reg      <= last_reg ? '0 : root_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        last_reg <= last_next;
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        if (out_load)
        begin
            energy_out_reg <= root_reg;
            onset_out_reg  <= onset_val;
            last_out_reg   <= last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {onset_out_reg, energy_out_reg};
    assign m_axis_tlast  = last_out_reg;

    `ASSERT_IMPLIES(a_divisor_nonzero, clk, rst_n, job_pop, job_data[SUM_W +: AV_W] != '0)
    `ASSERT_IMPLIES(a_root_range, clk, rst_n, out_load, root_reg <= 16'h8000)

endmodule

@@ design/framed_rms_energy_onset_unit.sv @@
// ----------------------------------------------------------------------------
// framed_rms_energy_onset_unit
// Short-time RMS energy and onset over hopped frames of a sample stream.
// ----------------------------------------------------------------------------
// Samples are taken at one per cycle. Each frame of HOPS_PER_FRAME hop
// blocks gives one word of energy and onset, posted when the frame's last
// block completes, or early with the samples so far when tlast marks the
// end of the stream (that word carries tlast, and all state clears).
// In the back end each frame passes the one-bit-per-cycle divider, then the
// two-bit-per-cycle root, and no new job is taken until its word is loaded;
// SUM_W, the dividend width, is 31 + clog2(HOP_LENGTH * HOPS_PER_FRAME).
// A four-entry job queue sits between the accumulator and the back end;
// sample intake stalls only while that queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module framed_rms_energy_onset_unit
    import frms_pkg::*;
#(
    parameter int HOP_LENGTH     = HOP_LENGTH_DEF,
    parameter int HOPS_PER_FRAME = HOPS_PER_FRAME_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,   // sample
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [2*ROOT_W-1:0] m_axis_tdata,   // energy, onset
    output logic                m_axis_tlast
);

    localparam int FRAME_LEN = HOP_LENGTH * HOPS_PER_FRAME;
    localparam int SUM_W     = SQ_W + $clog2(FRAME_LEN);
    localparam int AV_W      = $clog2(FRAME_LEN + 1);
    localparam int JOB_W     = SUM_W + AV_W + 1;

    logic             job_valid;
    logic [JOB_W-1:0] job_data;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic [JOB_W-1:0] q_data;

    frms_front #(
        .HOP_LENGTH     (HOP_LENGTH),
        .HOPS_PER_FRAME (HOPS_PER_FRAME),
        .SUM_W          (SUM_W),
        .AV_W           (AV_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .job_valid     (job_valid),
        .job_data      (job_data),
        .job_ready     (!q_full)
    );

    frms_queue #(
        .W     (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_valid),
        .push_data (job_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    frms_back #(
        .SUM_W (SUM_W),
        .AV_W  (AV_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (!q_empty),
        .job_data      (q_data),
        .job_pop       (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ tb/sv/framed_rms_energy_onset_unit_test.sv @@
// ----------------------------------------------------------------------------
// framed_rms_energy_onset_unit_test
// Self-checking bench for the framed RMS energy and onset unit.
// ----------------------------------------------------------------------------
// A table of constant-sample streams runs first: single samples at the
// extremes, a frame of full-scale negative samples, frames that complete on
// the end mark, and end marks inside partial frames. Random streams follow,
// mostly short ones ended by tlast, with some that run over several hops.
// Every accepted sample is run through a bit-exact model of the frame
// arithmetic kept here, and each output word is checked against the oldest
// pending prediction. Both stream sides idle at random, and the output side
// holds off once for a long stretch so that the job queue fills up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module framed_rms_energy_onset_unit_test;
    import frms_pkg::*;

    localparam int HOP             = HOP_LENGTH_DEF;
    localparam int HOPS            = HOPS_PER_FRAME_DEF;
    localparam int FRAME           = HOP * HOPS;
    localparam int RANDOM_SAMPLES  = 1000;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int BURST_STREAMS   = 12;
    localparam int DRAIN_CYCLES    = 200;
    localparam int MISMATCH_PRINTS = 10;

    typedef enum int
    {
        AMP_FULL,
        AMP_SCALED,
        AMP_CONSTANT,
        AMP_EXTREME
    } amp_mode_t;

    typedef struct packed
    {
        logic [ROOT_W-1:0] energy;
        logic [ROOT_W-1:0] onset;
        logic              last;
    } frame_word_t;

    typedef struct
    {
        logic [SAMPLE_W-1:0] value;
        int                  count;
        bit                  eos;
        bit                  known;
        logic [ROOT_W-1:0]   energy;
        logic [ROOT_W-1:0]   onset;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata;   // sample
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [2*ROOT_W-1:0] m_axis_tdata;   // energy, onset
    logic                m_axis_tlast;

    // energy model state
    logic [63:0]   held_sums [HOPS];
    logic [63:0]   open_sum;
    int unsigned   open_pos;
    int unsigned   held_count;
    logic [15:0]   last_energy;

    frame_word_t   frames_due [$];
    int            fault_count;
    int            src_idle_pct;
    int            sink_idle_pct;
    bit            hold_request;

    // constant streams; energy and onset are typed in where known outright
    stim_row_t directed_rows [13] = '{
        '{16'h0000,            1, 1'b1, 1'b1, 16'd0,     16'd0},
        '{16'h7FFF,            1, 1'b1, 1'b1, 16'd32767, 16'd32767},
        '{16'h8000,            1, 1'b1, 1'b1, 16'd32768, 16'd32768},
        '{16'hFFFF,            1, 1'b1, 1'b1, 16'd1,     16'd1},
        // full-scale negative frame completing on the end mark
        '{16'h8000,        FRAME, 1'b1, 1'b1, 16'd32768, 16'd32768},
        '{16'h7FFF,        FRAME, 1'b0, 1'b0, 16'd0,     16'd0},
        // one more hop of silence gives a quieter overlapping frame
        '{16'h0000,          HOP, 1'b0, 1'b0, 16'd0,     16'd0},
        // end mark a few samples into the open block of a partial frame
        '{16'h0064,            5, 1'b1, 1'b0, 16'd0,     16'd0},
        '{16'h03E8,          300, 1'b1, 1'b1, 16'd1000,  16'd1000},
        '{16'hFFFB,        2*HOP, 1'b1, 1'b1, 16'd5,     16'd5},
        // end mark on the closing sample of the first block
        '{16'h00C8,          HOP, 1'b1, 1'b1, 16'd200,   16'd200},
        // second frame completes on the end mark with no rise
        '{16'h7FFF,    FRAME+HOP, 1'b1, 1'b1, 16'd32767, 16'd0},
        // end mark on the first sample after a full frame
        '{16'h8001,      FRAME+1, 1'b1, 1'b1, 16'd32767, 16'd0}
    };

    framed_rms_energy_onset_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int unsigned floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = 64'd0;
        for (int b = 16; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root[31:0];
    endfunction

    function automatic void clear_energy_state();
        for (int i = 0; i < HOPS; i++)
            held_sums[i] = 64'd0;
        open_sum    = 64'd0;
        open_pos    = 0;
        held_count  = 0;
        last_energy = 16'd0;
    endfunction

    function automatic frame_word_t post_frame(input logic [63:0] available, input bit eos);
        logic [63:0]  total;
        int unsigned  root;
        frame_word_t  word;
        total = open_sum;
        for (int i = 0; i < held_count && i < HOPS; i++)
            total += held_sums[i];
        root        = floor_root(total / available);
        word.energy = root[15:0];
        word.onset  = (root > last_energy) ? 16'(root - last_energy) : 16'd0;
        word.last   = eos;
        last_energy = root[15:0];
        return word;
    endfunction

    // advance the frame model by one sample; made is set when a word is due
    function automatic void step_frame_energy(input logic [SAMPLE_W-1:0] smp, input bit eos,
                                              output bit made, output frame_word_t word);
        logic [16:0] mag;
        bit          block_end;
        mag       = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        block_end = (open_pos >= HOP - 1);
        made      = 1'b0;
        word      = '0;
        open_sum += 64'(mag) * 64'(mag);
        if (block_end && held_count >= HOPS - 1)
        begin
            word = post_frame(64'(FRAME), eos);
            made = 1'b1;
            if (eos)
                clear_energy_state();
            else
            begin
                if (held_count > 0 && held_count < HOPS)
                begin
                    for (int i = 0; i + 1 < held_count; i++)
                        held_sums[i] = held_sums[i + 1];
                    held_sums[held_count - 1] = open_sum;
                end
                open_sum = 64'd0;
                open_pos = 0;
            end
        end
        else if (eos)
        begin
            word = post_frame(64'(held_count) * HOP + 64'(open_pos) + 64'd1, 1'b1);
            made = 1'b1;
            clear_energy_state();
        end
        else if (block_end)
        begin
            if (held_count < HOPS)
            begin
                held_sums[held_count] = open_sum;
                held_count++;
            end
            open_sum = 64'd0;
            open_pos = 0;
        end
        else
            open_pos++;
    endfunction

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= MISMATCH_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic void check_frame(input logic [2*ROOT_W-1:0] data, input logic last);
        frame_word_t want;
        if (frames_due.size() == 0)
        begin
            note_fault($sformatf("unexpected word energy=%0d onset=%0d last=%0b",
                                 data[ROOT_W-1:0], data[2*ROOT_W-1:ROOT_W], last));
            return;
        end
        want = frames_due.pop_front();
        if (data[ROOT_W-1:0] !== want.energy)
            note_fault($sformatf("energy want %0d got %0d", want.energy, data[ROOT_W-1:0]));
        if (data[2*ROOT_W-1:ROOT_W] !== want.onset)
            note_fault($sformatf("onset want %0d got %0d", want.onset,
                                 data[2*ROOT_W-1:ROOT_W]));
        if (last !== want.last)
            note_fault($sformatf("last want %0b got %0b", want.last, last));
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_frame(m_axis_tdata, m_axis_tlast);
    end

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready = 1'b0;
            end
            else
                m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // offer one word at a falling edge and hold it until accepted
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input bit eos,
                               input bit typed, input frame_word_t typed_word);
        bit          made;
        frame_word_t word;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = smp;
        s_axis_tlast  = eos;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        step_frame_energy(smp, eos, made, word);
        if (made)
            frames_due = {frames_due, (typed ? typed_word : word)};
        @(negedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_sample(input amp_mode_t mode, input int amp,
                                                        input logic [SAMPLE_W-1:0] fixed);
        int v;
        case (mode)
            AMP_FULL:
                v = $urandom_range(0, 65535);
            AMP_SCALED:
                v = $urandom_range(0, 2 * amp) - amp;
            AMP_CONSTANT:
                v = int'(fixed);
            default:
            begin
                case ($urandom_range(3))
                    0: v = 32'h0000_8000;
                    1: v = 32'h0000_7FFF;
                    2: v = 32'h0000_FFFF;
                    default: v = 32'h0000_0000;
                endcase
            end
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic send_stream(input int len);
        amp_mode_t           mode;
        int                  amp;
        logic [SAMPLE_W-1:0] fixed;
        frame_word_t         none;
        none  = '0;
        mode  = amp_mode_t'($urandom_range(AMP_EXTREME));
        amp   = 0;
        fixed = SAMPLE_W'($urandom_range(0, 65535));
        for (int i = 0; i < len; i++)
        begin
            // vary loudness per hop so onset sees rises and falls
            if (i % HOP == 0)
                amp = $urandom_range(0, 32767) >> $urandom_range(0, 15);
            send_sample(draw_sample(mode, amp, fixed), i == len - 1, 1'b0, none);
        end
    endtask

    initial
    begin
        int          pick;
        int          samples_sent;
        int          len;
        bit          pressed;
        frame_word_t typed_word;
        rst_n            = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tlast     = 1'b0;
        hold_request     = 1'b0;
        src_idle_pct     = 25;
        sink_idle_pct    = 68;
        fault_count      = 0;
        pressed          = 1'b0;
        samples_sent     = 0;
        clear_energy_state();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
        begin
            typed_word.energy = directed_rows[r].energy;
            typed_word.onset  = directed_rows[r].onset;
            typed_word.last   = 1'b1;
            for (int i = 0; i < directed_rows[r].count; i++)
                send_sample(directed_rows[r].value,
                            directed_rows[r].eos && (i == directed_rows[r].count - 1),
                            directed_rows[r].known && (i == directed_rows[r].count - 1),
                            typed_word);
        end

        while (samples_sent < RANDOM_SAMPLES)
        begin
            if (samples_sent < RANDOM_SAMPLES / 3)
            begin
                src_idle_pct  = 25;
                sink_idle_pct = 68;
            end
            else if (samples_sent < 2 * RANDOM_SAMPLES / 3)
            begin
                src_idle_pct  = 68;
                sink_idle_pct = 25;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
                if (!pressed)
                begin
                    // block the output and keep feeding until intake stalls
                    pressed      = 1'b1;
                    hold_request = 1'b1;
                    for (int k = 0; k < BURST_STREAMS; k++)
                        send_stream(1);
                    samples_sent += BURST_STREAMS;
                end
            end
            pick = $urandom_range(99);
            if (pick < 75)
                len = $urandom_range(1, 300);
            else if (pick < 90)
                len = $urandom_range(FRAME - 8, FRAME + HOP + 40);
            else
                len = $urandom_range(FRAME + HOP, FRAME + 5 * HOP);
            // keep the random part within its sample budget
            if (samples_sent + len > RANDOM_SAMPLES)
                len = RANDOM_SAMPLES - samples_sent;
            if (len > 0)
            begin
                send_stream(len);
                samples_sent += len;
            end
        end
        s_axis_tvalid = 1'b0;

        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0 && frames_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/frms_pkg.sv
design/frms_queue.sv
design/frms_front.sv
design/frms_back.sv
design/framed_rms_energy_onset_unit.sv
tb/sv/framed_rms_energy_onset_unit_test.sv
